@@ design/fwba_pkg.sv @@
package fwba_pkg;

    localparam int unsigned DEF_MAX_ANTENNAS = 16;
    localparam int unsigned DEF_MAX_CHANNELS = 64;
    localparam int unsigned DEF_MAX_CORR     = 4;
    localparam int unsigned DEF_SUM_WIDTH    = 48;

    localparam logic [2:0] REG_AVERAGE_MODE  = 3'd0;
    localparam logic [2:0] REG_ANTENNA_COUNT = 3'd1;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [2:0] REG_CORR_COUNT    = 3'd3;
    localparam logic [2:0] REG_CROSS_FIRST   = 3'd4;
    localparam logic [2:0] REG_CROSS_SECOND  = 3'd5;

    localparam logic [1:0] MODE_BASELINE = 2'd0;
    localparam logic [1:0] MODE_ALL      = 2'd1;
    localparam logic [1:0] MODE_ANTENNA  = 2'd2;

    localparam logic KIND_ACCUMULATE = 1'b0;
    localparam logic KIND_READOUT    = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_RD,
        ST_MUL,
        ST_WR,
        ST_DIV,
        ST_OUT
    } state_t;

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ design/fwba_div.sv @@
module fwba_div
    import fwba_pkg::*;
#(
    parameter int unsigned SUM_WIDTH = DEF_SUM_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  div_ctrl_t                   ctrl,
    input  logic signed [SUM_WIDTH-1:0] dividend,
    input  logic [31:0]                 divisor,
    output div_stat_t                   stat,
    output logic signed [15:0]          quotient
);

    // Restoring division on magnitudes, one quotient bit a cycle.
    localparam int unsigned CW = $clog2(SUM_WIDTH + 1);

    logic [SUM_WIDTH-1:0] q_reg, q_next;
    logic [32:0]          r_reg, r_next;
    logic [31:0]          d_reg, d_next;
    logic                 neg_reg, neg_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [32:0]          trial;
    logic [SUM_WIDTH-1:0] mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        mag       = dividend[SUM_WIDTH-1] ? -dividend : dividend;
        trial     = {r_reg[31:0], q_reg[SUM_WIDTH-1]};
        if (ctrl.start) begin
            q_next    = mag;
            r_next    = '0;
            d_next    = divisor;
            neg_next  = dividend[SUM_WIDTH-1];
            cnt_next  = CW'(SUM_WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[SUM_WIDTH-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[SUM_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Saturate the magnitude quotient to 16 bits with its sign.
    always_comb begin
        if (neg_reg) begin
            if (q_reg > SUM_WIDTH'(32768)) quotient = 16'sh8000;
            else quotient = 16'(-q_reg);
        end else begin
            if (q_reg > SUM_WIDTH'(32767)) quotient = 16'sh7fff;
            else quotient = 16'(q_reg);
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ design/fwba_store.sv @@
module fwba_store
    import fwba_pkg::*;
#(
    parameter int unsigned DEPTH     = 34816,
    parameter int unsigned SUM_WIDTH = DEF_SUM_WIDTH
) (
    input  logic                         aclk,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [2*SUM_WIDTH+32:0]      wr_data,
    output logic [2*SUM_WIDTH+32:0]      rd_data
);

    // Each word holds flag, real sum, imaginary sum and weight sum.
    logic [2*SUM_WIDTH+32:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

@@ design/flagged_weighted_baseline_averager_unit.sv @@
// Channel   Direction  Ports                       Moves
// config    in         psel/penable/pwrite/paddr   register writes and reads
// input     in         s_axis_t*                   one visibility cell or readout request
// result    out        m_axis_t*                   one averaged cell per readout
//
// After reset a clearing pass writes every cell of the store, one per cycle, before the
// first item. An accumulate passes through the store read-modify-write and the weight
// multipliers, and once more for the second slot in per-antenna mode. A readout forms two
// quotients, real part then imaginary part, through the shared serial divider; an ignored
// item goes back to idle from the read state. Only a finished result stalls.
module flagged_weighted_baseline_averager_unit
    import fwba_pkg::*;
#(
    parameter int unsigned MAX_ANTENNAS = DEF_MAX_ANTENNAS,
    parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int unsigned MAX_CORR     = DEF_MAX_CORR,
    parameter int unsigned SUM_WIDTH    = DEF_SUM_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: first_antenna, second_antenna, channel, correlation, vis_re, vis_im,
    //        weight, cell_flagged, zero fill (72 bits)
    input  logic [71:0] s_axis_tdata,
    // tuser: kind
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: avg_re, avg_im, weight_total, out_flagged, slot_seen, zero fill (72 bits)
    output logic [71:0] m_axis_tdata
);

    localparam int unsigned NSLOTS = MAX_ANTENNAS * (MAX_ANTENNAS + 1) / 2;
    localparam int unsigned DEPTH  = NSLOTS * MAX_CHANNELS * MAX_CORR;
    localparam int unsigned AW     = $clog2(DEPTH);
    localparam int unsigned SW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int unsigned WW     = 2 * SUM_WIDTH + 33;
    localparam logic signed [SUM_WIDTH-1:0] SMAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SMIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // Configuration registers.
    logic [1:0] mode_reg;
    logic [4:0] nant_reg;
    logic [6:0] nch_reg;
    logic [2:0] ncor_reg;
    logic [1:0] chf_reg, chs_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_BASELINE;
            nant_reg <= 5'd16;
            nch_reg  <= 7'd64;
            ncor_reg <= 3'd4;
            chf_reg  <= 2'd0;
            chs_reg  <= 2'd0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_AVERAGE_MODE:  mode_reg <= pwdata[1:0];
                REG_ANTENNA_COUNT: nant_reg <= pwdata[4:0];
                REG_CHANNEL_COUNT: nch_reg  <= pwdata[6:0];
                REG_CORR_COUNT:    ncor_reg <= pwdata[2:0];
                REG_CROSS_FIRST:   chf_reg  <= pwdata[1:0];
                REG_CROSS_SECOND:  chs_reg  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_AVERAGE_MODE:  prdata = {30'd0, mode_reg};
            REG_ANTENNA_COUNT: prdata = {27'd0, nant_reg};
            REG_CHANNEL_COUNT: prdata = {25'd0, nch_reg};
            REG_CORR_COUNT:    prdata = {29'd0, ncor_reg};
            REG_CROSS_FIRST:   prdata = {30'd0, chf_reg};
            REG_CROSS_SECOND:  prdata = {30'd0, chs_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // Effective counts, saturated at the build limits.
    logic [31:0] n_eff, nch_eff, ncor_eff;
    assign n_eff    = (32'(nant_reg) > MAX_ANTENNAS) ? MAX_ANTENNAS : 32'(nant_reg);
    assign nch_eff  = (32'(nch_reg) > MAX_CHANNELS) ? MAX_CHANNELS : 32'(nch_reg);
    assign ncor_eff = (32'(ncor_reg) > MAX_CORR) ? MAX_CORR : 32'(ncor_reg);

    // Input item fields.
    logic [3:0]         in_a1, in_a2;
    logic [5:0]         in_ch;
    logic [1:0]         in_co;
    logic signed [15:0] in_re, in_im;
    logic [15:0]        in_w;
    logic               in_fl;
    assign in_a1 = s_axis_tdata[3:0];
    assign in_a2 = s_axis_tdata[7:4];
    assign in_ch = s_axis_tdata[13:8];
    assign in_co = s_axis_tdata[15:14];
    assign in_re = s_axis_tdata[31:16];
    assign in_im = s_axis_tdata[47:32];
    assign in_w  = s_axis_tdata[63:48];
    assign in_fl = s_axis_tdata[64];

    // Captured item.
    logic               kind_reg;
    logic [3:0]         a1_reg, a2_reg;
    logic [5:0]         ch_reg;
    logic [1:0]         co_reg;
    logic signed [15:0] re_reg, im_reg;
    logic [16:0]        w_reg;
    logic               fl_reg;

    // Sequencer working registers.
    state_t             state_reg, state_next;
    logic [AW:0]        clr_reg, clr_next;
    logic               second_reg, second_next;
    logic               two_reg, two_next;
    logic               ok_reg, ok_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic [1:0]         jc_reg, jc_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic               phase_reg, phase_next;
    logic [NSLOTS-1:0]  seen_reg, seen_next;
    logic signed [33:0] pr_re_reg, pr_im_reg, pr_re_next, pr_im_next;
    logic signed [15:0] qre_reg, qre_next;
    logic               mvalid_reg, mvalid_next;
    logic [71:0]        mdata_reg, mdata_next;
    div_ctrl_t          dctrl;
    div_stat_t          dstat;
    logic signed [15:0] dq;

    // Store port.
    logic [WW-1:0] rd_data, wr_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;

    logic                        c_fl;
    logic signed [SUM_WIDTH-1:0] c_re, c_im;
    logic [31:0]                 c_w;
    assign c_fl = rd_data[WW-1];
    assign c_re = rd_data[2*SUM_WIDTH+31:SUM_WIDTH+32];
    assign c_im = rd_data[SUM_WIDTH+31:32];
    assign c_w  = rd_data[31:0];

    fwba_store #(.DEPTH(DEPTH), .SUM_WIDTH(SUM_WIDTH)) u_store (
        .aclk    (aclk),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    fwba_div #(.SUM_WIDTH(SUM_WIDTH)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (dctrl),
        .dividend (phase_next ? c_im : c_re),
        .divisor  (c_w),
        .stat     (dstat),
        .quotient (dq)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            mvalid_reg <= 1'b0;
            seen_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            mvalid_reg <= mvalid_next;
            seen_reg   <= seen_next;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            kind_reg <= s_axis_tuser;
            a1_reg   <= in_a1;
            a2_reg   <= in_a2;
            ch_reg   <= in_ch;
            co_reg   <= in_co;
            re_reg   <= in_re;
            im_reg   <= in_im;
            w_reg    <= (in_w == 16'd0) ? 17'd1 : {1'b0, in_w};
            fl_reg   <= in_fl;
        end
        second_reg <= second_next;
        two_reg    <= two_next;
        ok_reg     <= ok_next;
        slot_reg   <= slot_next;
        jc_reg     <= jc_next;
        addr_reg   <= addr_next;
        phase_reg  <= phase_next;
        pr_re_reg  <= pr_re_next;
        pr_im_reg  <= pr_im_next;
        qre_reg    <= qre_next;
        mdata_reg  <= mdata_next;
    end

    // Slot computation from the captured item.
    logic [31:0] bl_slot;
    logic        bl_ok, cell_ok;
    logic [1:0]  jc_c;
    assign bl_slot = (32'(a1_reg) * (2 * n_eff - 32'(a1_reg) + 32'd1)) / 2
                     + 32'(a2_reg) - 32'(a1_reg);
    assign bl_ok   = (a1_reg <= a2_reg) && (32'(a2_reg) < n_eff);
    assign cell_ok = (32'(ch_reg) < nch_eff) && (32'(co_reg) < ncor_eff);
    always_comb begin
        jc_c = co_reg;
        if (chf_reg != chs_reg) begin
            if (co_reg == chf_reg) jc_c = chs_reg;
            else if (co_reg == chs_reg) jc_c = chf_reg;
        end
    end

    logic               upd_fl, acc;
    logic signed [SUM_WIDTH-1:0] base_re, base_im, nre, nim;
    logic [31:0]        base_w, nw;
    logic [32:0]        wsum;
    logic signed [SUM_WIDTH:0] tre, tim;

    always_comb begin
        base_re = c_fl && !fl_reg ? '0 : c_re;
        base_im = c_fl && !fl_reg ? '0 : c_im;
        base_w  = c_fl && !fl_reg ? '0 : c_w;
        acc     = !fl_reg || c_fl;
        upd_fl  = c_fl && fl_reg;
        tre     = $signed({base_re[SUM_WIDTH-1], base_re}) + (SUM_WIDTH+1)'(pr_re_reg);
        tim     = $signed({base_im[SUM_WIDTH-1], base_im}) + (SUM_WIDTH+1)'(pr_im_reg);
        nre = (tre > $signed({SMAX[SUM_WIDTH-1], SMAX})) ? SMAX :
              (tre < $signed({SMIN[SUM_WIDTH-1], SMIN})) ? SMIN : tre[SUM_WIDTH-1:0];
        nim = (tim > $signed({SMAX[SUM_WIDTH-1], SMAX})) ? SMAX :
              (tim < $signed({SMIN[SUM_WIDTH-1], SMIN})) ? SMIN : tim[SUM_WIDTH-1:0];
        wsum = {1'b0, base_w} + 33'(w_reg);
        nw   = wsum[32] ? 32'hffff_ffff : wsum[31:0];
    end

    logic [3:0] ant_c;
    logic [1:0] co_c;
    assign ant_c = second_reg ? a2_reg : a1_reg;
    assign co_c  = second_reg ? jc_reg : co_reg;

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        second_next   = second_reg;
        two_next      = two_reg;
        ok_next       = ok_reg;
        slot_next     = slot_reg;
        jc_next       = jc_reg;
        addr_next     = addr_reg;
        phase_next    = phase_reg;
        seen_next     = seen_reg;
        pr_re_next    = pr_re_reg;
        pr_im_next    = pr_im_reg;
        qre_next      = qre_reg;
        mvalid_next   = mvalid_reg;
        mdata_next    = mdata_reg;
        s_axis_tready = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = addr_reg;
        wr_data       = {1'b1, {(WW-1){1'b0}}};
        rd_addr       = addr_reg;
        dctrl.start   = 1'b0;
        if (mvalid_reg && m_axis_tready) mvalid_next = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_reg[AW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(DEPTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                second_next   = 1'b0;
                phase_next    = 1'b0;
                if (s_axis_tvalid) state_next = ST_ADDR;
            end
            ST_ADDR: begin
                // Resolve the slot for this update and check validity.
                two_next = 1'b0;
                jc_next  = jc_c;
                if (mode_reg == MODE_ALL) begin
                    ok_next   = cell_ok;
                    slot_next = '0;
                end else if (mode_reg == MODE_ANTENNA) begin
                    if (kind_reg == KIND_READOUT) begin
                        ok_next = cell_ok && 32'(a1_reg) < n_eff;
                    end else begin
                        ok_next  = cell_ok && 32'(a1_reg) < n_eff && 32'(a2_reg) < n_eff;
                        two_next = 32'(jc_c) < ncor_eff;
                    end
                    slot_next = SW'(ant_c);
                end else begin
                    ok_next   = cell_ok && bl_ok;
                    slot_next = SW'(bl_slot);
                end
                if (second_reg) slot_next = SW'(a2_reg);
                state_next = ST_RD;
            end
            ST_RD: begin
                addr_next = AW'((32'(slot_reg) * MAX_CHANNELS + 32'(ch_reg)) * MAX_CORR
                                + 32'(co_c));
                if (!ok_reg) begin
                    if (kind_reg == KIND_READOUT) begin
                        // An earlier result still waiting holds this one back.
                        if (!(mvalid_reg && !m_axis_tready)) begin
                            mdata_next  = {6'd0, 1'b0, 1'b1, 32'd0, 32'd0};
                            mvalid_next = 1'b1;
                            state_next  = ST_IDLE;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    if (kind_reg == KIND_ACCUMULATE && !second_reg) begin
                        seen_next[slot_reg] = 1'b1;
                        if (mode_reg == MODE_ANTENNA) seen_next[SW'(a2_reg)] = 1'b1;
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                // Store read issued from addr_reg; the weight multipliers form w*value.
                pr_re_next = 34'(re_reg) * $signed({1'b0, w_reg});
                pr_im_next = 34'(second_reg ? -34'(im_reg) : 34'(im_reg))
                             * $signed({1'b0, w_reg});
                state_next = (kind_reg == KIND_READOUT) ? ST_DIV : ST_WR;
            end
            ST_WR: begin
                wr_en = acc;
                wr_data = {upd_fl, nre, nim, nw};
                if (!second_reg && two_reg) begin
                    second_next = 1'b1;
                    state_next  = ST_ADDR;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (!phase_reg && !dstat.busy && !dstat.done) begin
                    // The store word has arrived, so the real part can go in.
                    dctrl.start = 1'b1;
                end else if (dstat.done) begin
                    if (!phase_reg) begin
                        qre_next    = (c_w == 32'd0) ? 16'sd0 : dq;
                        phase_next  = 1'b1;
                        dctrl.start = 1'b1;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!(mvalid_reg && !m_axis_tready)) begin
                    mdata_next  = {6'd0, seen_reg[slot_reg], c_fl, c_w,
                                   (c_w == 32'd0) ? 16'sd0 : dq, qre_reg};
                    mvalid_next = 1'b1;
                    wr_en       = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;

    // Clearing pass finishes before any item is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_axis_tready)
        else $error("item taken during clearing pass");

    // A new result is never loaded over one that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("pending result lost");

    // The divider only runs while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        dstat.busy |-> state_reg == ST_DIV)
        else $error("divider busy outside readout");

endmodule
